/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, off while reset is high.
`define CTM_ASSERT_NOW(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: same-cycle check failed");

// Implication checked in the next cycle, off while reset is high.
`define CTM_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

// Implication checked in the next cycle, always active.
`define CTM_ASSERT_NEXT_ALWAYS(lbl, clk, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

/* sv/ctm_pkg.sv */
package ctm_pkg;

  // Burst length after reset.
  localparam logic [7:0] DEFAULT_COUNT = 8'd100;

  // Where the reported level came from.
  typedef enum logic [1:0] {
    SRC_CORRIDOR = 2'd0,
    SRC_UPPER    = 2'd1,
    SRC_PLAIN    = 2'd2
  } source_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_BASE,
    BK_SCAN_UPPER,
    BK_DIV_UPPER,
    BK_SCAN_CORR,
    BK_DIV_LEVEL,
    BK_EMIT
  } back_state_t;

endpackage

/* sv/ctm_store.sv */
module ctm_store #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ctm_queue.sv */
module ctm_queue #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign not_empty = (fill != '0);
  assign head      = entry[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/ctm_front.sv */
module ctm_front #(
  parameter int MAX_SAMPLES = 128,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [7:0]                       sample_count,
  input  logic                             accept,
  input  logic [SAMPLE_BITS-1:0]           sample,
  output logic                             mem_we,
  output logic [$clog2(MAX_SAMPLES)-1:0]   mem_waddr,
  output logic                             job_push,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] job_count,
  output logic [SAMPLE_BITS+$clog2(MAX_SAMPLES+1)-1:0] job_sum
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;

  logic [CNT_W-1:0] fill_count;
  logic [SUM_W-1:0] running_sum;
  logic [CMP_W-1:0] count_ext;
  logic [CNT_W-1:0] burst_len;
  logic [CNT_W-1:0] fill_inc;
  logic [SUM_W-1:0] sum_inc;
  logic             close;

  // Clamp the burst length to 1..MAX_SAMPLES.
  assign count_ext = CMP_W'(sample_count);
  always_comb begin
    if (count_ext == '0) begin
      burst_len = CNT_W'(1);
    end else if (count_ext > CMP_W'(MAX_SAMPLES)) begin
      burst_len = CNT_W'(MAX_SAMPLES);
    end else begin
      burst_len = CNT_W'(count_ext);
    end
  end

  assign fill_inc = fill_count + 1'b1;
  assign sum_inc  = running_sum + SUM_W'(sample);
  assign close    = (fill_inc >= burst_len);

  // Each accepted item goes to the next buffer slot.
  assign mem_we    = accept;
  assign mem_waddr = fill_count[ADDR_W-1:0];

  // The closing item hands the burst to the back end.
  assign job_push  = accept && close;
  assign job_count = fill_inc;
  assign job_sum   = sum_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      running_sum <= '0;
    end else if (accept) begin
      if (close) begin
        fill_count  <= '0;
        running_sum <= '0;
      end else begin
        fill_count  <= fill_inc;
        running_sum <= sum_inc;
      end
    end
  end

endmodule

/* sv/ctm_back.sv */
module ctm_back #(
  parameter int MAX_SAMPLES = 128,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             job_valid,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0] job_count,
  input  logic [SAMPLE_BITS+$clog2(MAX_SAMPLES+1)-1:0] job_sum,
  output logic                             job_pop,
  output logic                             mem_busy,
  output logic [$clog2(MAX_SAMPLES)-1:0]   mem_raddr,
  input  logic [SAMPLE_BITS-1:0]           mem_rdata,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [SAMPLE_BITS-1:0]           level,
  output logic [1:0]                       source
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  ctm_pkg::back_state_t state;
  ctm_pkg::back_state_t state_next;

  // Shared restoring divider: one quotient bit per cycle.
  logic [SUM_W-1:0]  div_num;
  logic [CNT_W-1:0]  div_den;
  logic [CNT_W-1:0]  div_rem;
  logic [STEP_W-1:0] div_step;
  logic [CNT_W:0]    rem_sh;
  logic              rem_ge;
  logic [CNT_W-1:0]  rem_nx;
  logic [SUM_W-1:0]  num_nx;
  logic              div_last;
  logic              div_phase;

  // Scan over the buffer.
  logic [CNT_W-1:0]  scan_n;
  logic [CNT_W-1:0]  rd_idx;
  logic              rd_vld;
  logic              issue;
  logic              scan_phase;
  logic              scan_done;
  logic              hit_upper;
  logic              hit;
  logic [SUM_W-1:0]  acc_sum;
  logic [CNT_W-1:0]  acc_cnt;

  logic [SAMPLE_BITS-1:0] base_mean;
  logic [SAMPLE_BITS-1:0] upper_mean;
  logic [SAMPLE_BITS-1:0] res_level;
  ctm_pkg::source_t       res_src;
  logic                   out_load;

  assign rem_sh   = {div_rem, div_num[SUM_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_den});
  assign rem_nx   = rem_ge ? CNT_W'(rem_sh - {1'b0, div_den}) : CNT_W'(rem_sh);
  assign num_nx   = {div_num[SUM_W-2:0], rem_ge};
  assign div_last = (div_step == STEP_W'(SUM_W - 1));

  assign div_phase  = (state == ctm_pkg::BK_DIV_BASE) || (state == ctm_pkg::BK_DIV_UPPER) ||
                      (state == ctm_pkg::BK_DIV_LEVEL);
  assign scan_phase = (state == ctm_pkg::BK_SCAN_UPPER) || (state == ctm_pkg::BK_SCAN_CORR);
  assign issue      = scan_phase && (rd_idx != scan_n);
  assign scan_done  = scan_phase && (rd_idx == scan_n) && !rd_vld;
  assign mem_raddr  = rd_idx[ADDR_W-1:0];

  assign hit_upper = (mem_rdata >= base_mean);
  assign hit       = (state == ctm_pkg::BK_SCAN_CORR) ? (hit_upper && (mem_rdata <= upper_mean))
                                                      : hit_upper;

  assign job_pop  = (state == ctm_pkg::BK_IDLE) && job_valid;
  assign out_load = (state == ctm_pkg::BK_EMIT) && (!result_valid || !result_stall);

  // The buffer is in use from the start of a job until the last scan ends.
  assign mem_busy = (state != ctm_pkg::BK_IDLE) && (state != ctm_pkg::BK_DIV_LEVEL) &&
                    (state != ctm_pkg::BK_EMIT);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ctm_pkg::BK_IDLE: begin
        if (job_valid) begin
          state_next = ctm_pkg::BK_DIV_BASE;
        end
      end
      ctm_pkg::BK_DIV_BASE: begin
        if (div_last) begin
          state_next = ctm_pkg::BK_SCAN_UPPER;
        end
      end
      ctm_pkg::BK_SCAN_UPPER: begin
        if (scan_done) begin
          state_next = (acc_cnt == '0) ? ctm_pkg::BK_EMIT : ctm_pkg::BK_DIV_UPPER;
        end
      end
      ctm_pkg::BK_DIV_UPPER: begin
        if (div_last) begin
          state_next = ctm_pkg::BK_SCAN_CORR;
        end
      end
      ctm_pkg::BK_SCAN_CORR: begin
        if (scan_done) begin
          state_next = (acc_cnt == '0) ? ctm_pkg::BK_EMIT : ctm_pkg::BK_DIV_LEVEL;
        end
      end
      ctm_pkg::BK_DIV_LEVEL: begin
        if (div_last) begin
          state_next = ctm_pkg::BK_EMIT;
        end
      end
      ctm_pkg::BK_EMIT: begin
        if (out_load) begin
          state_next = ctm_pkg::BK_IDLE;
        end
      end
      default: state_next = ctm_pkg::BK_IDLE;
    endcase
  end

  // Read-data valid tracks the registered buffer read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
    end
  end

  // Divider, scan accumulators and pass results.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      div_num  <= job_sum;
      div_den  <= job_count;
      div_rem  <= '0;
      div_step <= '0;
      scan_n   <= job_count;
    end
    if (div_phase) begin
      div_num  <= num_nx;
      div_rem  <= rem_nx;
      div_step <= div_step + 1'b1;
      rd_idx   <= '0;
      acc_sum  <= '0;
      acc_cnt  <= '0;
      if (div_last) begin
        if (state == ctm_pkg::BK_DIV_BASE) begin
          base_mean <= num_nx[SAMPLE_BITS-1:0];
        end else if (state == ctm_pkg::BK_DIV_UPPER) begin
          upper_mean <= num_nx[SAMPLE_BITS-1:0];
        end else begin
          res_level <= num_nx[SAMPLE_BITS-1:0];
          res_src   <= ctm_pkg::SRC_CORRIDOR;
        end
      end
    end
    if (scan_phase) begin
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (rd_vld && hit) begin
        acc_sum <= acc_sum + SUM_W'(mem_rdata);
        acc_cnt <= acc_cnt + 1'b1;
      end
      if (scan_done) begin
        if (acc_cnt == '0) begin
          // Nothing selected: fall back to the previous average.
          if (state == ctm_pkg::BK_SCAN_UPPER) begin
            res_level <= base_mean;
            res_src   <= ctm_pkg::SRC_PLAIN;
          end else begin
            res_level <= upper_mean;
            res_src   <= ctm_pkg::SRC_UPPER;
          end
        end else begin
          div_num  <= acc_sum;
          div_den  <= acc_cnt;
          div_rem  <= '0;
          div_step <= '0;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      level  <= res_level;
      source <= res_src;
    end
  end

endmodule

/* sv/corridor_trimmed_mean.sv */
// Throughput: one sample per cycle inside a burst; after the closing item, input stalls
// while the burst waits and then until the last of the one or two scans of the
// single-read-port sample buffer ends; the bit-serial divider may still be running then.
// Reset: synchronous, clears control state and sets sample_count to 100; no buffer clear.
module corridor_trimmed_mean #(
  parameter int MAX_SAMPLES = 128,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [7:0]             cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [SAMPLE_BITS-1:0] level,
  output logic [1:0]             source
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int JOB_W  = SUM_W + CNT_W;

  logic [7:0]             sample_count;
  logic                   accept;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_rdata;
  logic                   job_push;
  logic [CNT_W-1:0]       push_count;
  logic [SUM_W-1:0]       push_sum;
  logic                   job_valid;
  logic                   job_pop;
  logic [JOB_W-1:0]       job_head;
  logic                   mem_busy;

  // Burst length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= ctm_pkg::DEFAULT_COUNT;
    end else if (cfg_write) begin
      sample_count <= cfg_data;
    end
  end

  // Hold off new samples while a burst waits or the back end still needs the buffer.
  assign sample_stall = job_valid || mem_busy;
  assign accept       = sample_valid && !sample_stall;

  ctm_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_count (sample_count),
    .accept       (accept),
    .sample       (sample),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .job_push     (job_push),
    .job_count    (push_count),
    .job_sum      (push_sum)
  );

  ctm_store #(
    .DEPTH(MAX_SAMPLES),
    .WIDTH(SAMPLE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (sample),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ctm_queue #(
    .WIDTH(JOB_W),
    .DEPTH(2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data ({push_sum, push_count}),
    .pop       (job_pop),
    .not_empty (job_valid),
    .head      (job_head)
  );

  ctm_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job_count    (job_head[CNT_W-1:0]),
    .job_sum      (job_head[JOB_W-1:CNT_W]),
    .job_pop      (job_pop),
    .mem_busy     (mem_busy),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .level        (level),
    .source       (source)
  );

endmodule

/* sv/ctm_checker.sv */
`include "assert_macros.svh"

module ctm_checker #(
  parameter int SAMPLE_BITS = 12
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   result_valid,
  input logic                   result_stall,
  input logic [SAMPLE_BITS-1:0] level,
  input logic [1:0]             source
);

  logic out_stalled;
  logic source_legal;

  // An offered result that the receiver holds off, and the set of legal source codes.
  assign out_stalled  = result_valid && result_stall;
  assign source_legal = (source == ctm_pkg::SRC_CORRIDOR) || (source == ctm_pkg::SRC_UPPER) ||
                        (source == ctm_pkg::SRC_PLAIN);

  // A stalled result stays offered.
  `CTM_ASSERT_NEXT(a_result_held, clk, rst, out_stalled, result_valid)

  // A stalled result keeps its payload.
  `CTM_ASSERT_NEXT(a_payload_held, clk, rst, out_stalled, $stable({level, source}))

  // Every offered result names a known source.
  `CTM_ASSERT_NOW(a_source_known, clk, rst, result_valid, source_legal)

  // No result is offered right after reset.
  `CTM_ASSERT_NEXT_ALWAYS(a_quiet_after_reset, clk, rst, !result_valid)

endmodule

bind corridor_trimmed_mean ctm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);
